// ===== src/rth_pkg.sv =====
// Shared types, constants and divide-step helper for the RGB to HSV pipeline.
package rth_pkg;

  localparam int unsigned CH_W    = 8;   // channel byte
  localparam int unsigned HUE_W   = 15;  // hue in 1/64 degree
  localparam int unsigned SAT_W   = 13;  // saturation Q1.12
  localparam int unsigned NUM_W   = 20;  // dividend width for both dividers
  localparam int unsigned HUE_QW  = 12;  // hue quotient bits (max 3840)
  localparam int unsigned SAT_QW  = 13;  // saturation quotient bits (max 4096)
  localparam int unsigned NSTAGE  = SAT_QW;  // one quotient bit per stage

  localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;   // 120 degrees
  localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;  // 240 degrees
  localparam logic [HUE_W-1:0] HUE_TURN  = 15'd23040;  // 360 degrees
  localparam logic [HUE_W-1:0] HUE_ZERO  = 15'd0;

  typedef struct packed {
    logic [CH_W-1:0]   hi;        // max channel
    logic [CH_W-1:0]   delta;     // max - min, divisor of the hue path
    logic [HUE_W-1:0]  base;      // sector base hue
    logic              neg;       // sector difference was negative
    logic              gray;      // delta == 0: hue and saturation are zero
    logic [CH_W-1:0]   hue_rem;
    logic [HUE_QW-1:0] hue_bits;  // dividend bits still to shift in
    logic [HUE_QW-1:0] hue_quo;
    logic [CH_W-1:0]   sat_rem;
    logic [SAT_QW-1:0] sat_bits;
    logic [SAT_QW-1:0] sat_quo;
  } pipe_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [CH_W:0] div_step(input logic [CH_W-1:0] rem,
                                             input logic            nb,
                                             input logic [CH_W-1:0] dvs);
    logic [CH_W:0] trial;
    logic [CH_W:0] diff;
    trial = {rem, nb};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      return {1'b1, diff[CH_W-1:0]};
    end else begin
      return {1'b0, trial[CH_W-1:0]};
    end
  endfunction

endpackage

// ===== src/rth_if.sv =====
// Stream interfaces for RGB pixels in and HSV results out.
interface rth_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [12:0] saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== src/rth_front.sv =====
// Front stage: max/min, hue sector, divider operand setup, registered.
module rth_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  rth_pix_if.sink           pix,
  input  logic              ready_i,
  output logic              valid_o,
  output rth_pkg::pipe_t    data_o
);
  import rth_pkg::*;

  logic              valid_q;
  pipe_t             data_q;
  pipe_t             data_d;
  logic              en;
  logic [CH_W-1:0]   hi, lo, delta, ad;
  logic [CH_W:0]     diff;
  logic [NUM_W-1:0]  hue_num, sat_num;

  assign en        = !valid_q || ready_i;
  assign pix.ready = en;

  always_comb begin
    hi = pix.red;
    lo = pix.red;
    if (pix.green > hi) hi = pix.green;
    if (pix.blue  > hi) hi = pix.blue;
    if (pix.green < lo) lo = pix.green;
    if (pix.blue  < lo) lo = pix.blue;
    delta = hi - lo;

    // sector pick, ties go to red then green
    if (pix.red == hi) begin
      diff = {1'b0, pix.green} - {1'b0, pix.blue};
    end else if (pix.green == hi) begin
      diff = {1'b0, pix.blue} - {1'b0, pix.red};
    end else begin
      diff = {1'b0, pix.red} - {1'b0, pix.green};
    end
    ad = diff[CH_W] ? (~diff[CH_W-1:0] + 8'd1) : diff[CH_W-1:0];

    // 3840 * |diff| as (x << 12) - (x << 8)
    hue_num = {ad, 12'b0} - {4'b0, ad, 8'b0};
    sat_num = {delta, 12'b0};

    data_d.hi    = hi;
    data_d.delta = delta;
    data_d.neg   = diff[CH_W];
    data_d.gray  = (delta == '0);
    if (pix.red == hi) begin
      data_d.base = diff[CH_W] ? HUE_TURN : HUE_ZERO;
    end else if (pix.green == hi) begin
      data_d.base = HUE_GREEN;
    end else begin
      data_d.base = HUE_BLUE;
    end
    data_d.hue_rem  = hue_num[NUM_W-1:HUE_QW];
    data_d.hue_bits = hue_num[HUE_QW-1:0];
    data_d.hue_quo  = '0;
    data_d.sat_rem  = {1'b0, sat_num[NUM_W-1:SAT_QW]};
    data_d.sat_bits = sat_num[SAT_QW-1:0];
    data_d.sat_quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= pix.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && pix.valid) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/rth_div_stage.sv =====
// One pipelined restoring-divide stage: a saturation quotient bit, and a hue quotient bit when DO_HUE is set.
module rth_div_stage #(
  parameter bit DO_HUE = 1'b1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rth_pkg::pipe_t  data_i,
  output logic            ready_o,
  output logic            valid_o,
  output rth_pkg::pipe_t  data_o,
  input  logic            ready_i
);
  import rth_pkg::*;

  logic          valid_q;
  pipe_t         data_q;
  pipe_t         data_d;
  logic [CH_W:0] hstep, sstep;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    sstep  = div_step(data_i.sat_rem, data_i.sat_bits[SAT_QW-1], data_i.hi);
    data_d.sat_rem  = sstep[CH_W-1:0];
    data_d.sat_bits = {data_i.sat_bits[SAT_QW-2:0], 1'b0};
    data_d.sat_quo  = {data_i.sat_quo[SAT_QW-2:0], sstep[CH_W]};
    hstep  = div_step(data_i.hue_rem, data_i.hue_bits[HUE_QW-1], data_i.delta);
    if (DO_HUE) begin
      data_d.hue_rem  = hstep[CH_W-1:0];
      data_d.hue_bits = {data_i.hue_bits[HUE_QW-2:0], 1'b0};
      data_d.hue_quo  = {data_i.hue_quo[HUE_QW-2:0], hstep[CH_W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/rth_back.sv =====
// Back stage: hue from sector base and quotient, gray override, output register.
module rth_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rth_pkg::pipe_t  data_i,
  output logic            ready_o,
  rth_hsv_if.source       hsv
);
  import rth_pkg::*;

  logic              valid_q;
  logic [HUE_W-1:0]  hue_q, hue_d;
  logic [SAT_W-1:0]  sat_q, sat_d;
  logic [CH_W-1:0]   bri_q;
  logic [HUE_W-1:0]  quo;
  logic              rnz;

  assign ready_o = !valid_q || hsv.ready;

  always_comb begin
    quo = {{(HUE_W-HUE_QW){1'b0}}, data_i.hue_quo};
    rnz = (data_i.hue_rem != '0);
    // negative difference: subtract the ceiling of the fraction
    if (data_i.neg) begin
      hue_d = data_i.base - quo - {{(HUE_W-1){1'b0}}, rnz};
    end else begin
      hue_d = data_i.base + quo;
    end
    sat_d = data_i.sat_quo;
    if (data_i.gray) begin
      hue_d = '0;
      sat_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= data_i.hi;
    end
  end

  assign hsv.valid      = valid_q;
  assign hsv.hue        = hue_q;
  assign hsv.saturation = sat_q;
  assign hsv.brightness = bri_q;

endmodule

// ===== src/rgb_to_hsv.sv =====
// Top level: RGB pixel to HSV converter, one pixel per clock.
// From input transfer to result valid a pixel passes the front stage, the 13 divide stages and the back stage.
// Throughput: one pixel per cycle while the output is not stalled; the 13 one-bit divide stages set the depth.
// Each stage holds its item while stalled and fills bubbles on its own.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; no payload reset.
module rgb_to_hsv (
  input  logic        clk_i,
  input  logic        rst_ni,
  rth_pix_if.sink     pix_i,
  rth_hsv_if.source   hsv_o
);
  import rth_pkg::*;

  // index 0 is the front stage output, index k the k-th divide stage output
  logic  vld [0:NSTAGE];
  logic  rdy [0:NSTAGE];
  pipe_t dat [0:NSTAGE];

  // Front: max, min, delta, sector choice and the two dividends.
  rth_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix     (pix_i),
    .ready_i (rdy[0]),
    .valid_o (vld[0]),
    .data_o  (dat[0])
  );

  // Divide chain: saturation takes 13 steps (4096*delta/max),
  // hue takes 12 steps (3840*|diff|/delta) and coasts through the last one.
  for (genvar k = 1; k <= NSTAGE; k++) begin : g_div
    rth_div_stage #(
      .DO_HUE (k <= HUE_QW)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k-1]),
      .data_i  (dat[k-1]),
      .ready_o (rdy[k-1]),
      .valid_o (vld[k]),
      .data_o  (dat[k]),
      .ready_i (rdy[k])
    );
  end

  // Back: sector base plus or minus quotient, gray pixels forced to zero.
  rth_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[NSTAGE]),
    .data_i  (dat[NSTAGE]),
    .ready_o (rdy[NSTAGE]),
    .hsv     (hsv_o)
  );

  // Hue always wraps into one turn.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (hsv_o.hue < HUE_TURN))
    else $error("hue out of range");

  // Saturation never exceeds one.
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (hsv_o.saturation <= 13'd4096))
    else $error("saturation above one");

  // Zero saturation only for gray pixels, which carry zero hue.
  a_gray_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && (hsv_o.saturation == '0)) |-> (hsv_o.hue == '0))
    else $error("gray pixel with nonzero hue");

  // A stalled front stage keeps its item.
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld[0] && !rdy[0]) |=> (vld[0] && $stable(dat[0])))
    else $error("front stage lost item under stall");

endmodule

// ===== tb/tb_rgb_to_hsv.sv =====
// Self-checking testbench for the rgb_to_hsv pixel converter: directed corners, then random pixels.
module tb_rgb_to_hsv;
  timeunit 1ns;
  timeprecision 1ps;

  import rth_pkg::*;

  // Fixed-point scale of the hue and saturation outputs.
  localparam int HUE_SECTOR  = 3840;   // 60 degrees in 1/64-degree units
  localparam int HUE_CIRCLE  = 23040;  // 360 degrees
  localparam int SAT_UNITY   = 4096;   // 1.0 in Q1.12
  localparam int CHAN_MAX    = 255;
  localparam int PIPE_DEPTH  = 15;     // input transfer to result valid
  localparam int N_CHUNKS    = 8;
  localparam int CHUNK_LEN   = 175;    // 8 x 175 = 1400 random pixels
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  brightness;
  } hsv_t;

  logic clk;
  logic rst_n;

  rth_pix_if pix ();
  rth_hsv_if hsv ();

  rgb_to_hsv uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .pix_i (pix),
    .hsv_o (hsv)
  );

  // Pixels waiting to be driven, and HSV results owed by the block, oldest first.
  pixel_t pixel_q[$];
  hsv_t   hsv_owed_q[$];

  logic pix_taken;   // input transfer seen at the last rising edge
  logic idle_en;     // random gaps on both sides while set
  int   src_gap;
  int   snk_gap;
  int   fail_cnt;
  int   n_checked;
  int   n_gray;
  int   n_directed;
  int   n_random;
  int   cycles;

  // Exact integer HSV. Ties for the max go to red, then green; negative hue
  // wraps by a full circle before the floor divide.
  function automatic hsv_t hsv_of(pixel_t px);
    int   r, g, b, hi, lo, delta, num;
    hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    delta = hi - lo;
    res.hue        = '0;
    res.saturation = '0;
    res.brightness = CH_W'(hi);
    if (hi != 0 && delta != 0) begin
      res.saturation = SAT_W'((SAT_UNITY * delta) / hi);
      if (r == hi) begin
        num = HUE_SECTOR * (g - b);
      end else if (g == hi) begin
        num = 2 * HUE_SECTOR * delta + HUE_SECTOR * (b - r);
      end else begin
        num = 4 * HUE_SECTOR * delta + HUE_SECTOR * (r - g);
      end
      if (num < 0) num += HUE_CIRCLE * delta;
      res.hue = HUE_W'(num / delta);
    end
    return res;
  endfunction

  // Byte a few steps off base, clamped to the channel range.
  function automatic logic [CH_W-1:0] near_byte(int base);
    int v;
    v = base + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > CHAN_MAX) v = CHAN_MAX;
    return CH_W'(v);
  endfunction

  // Random pixel, biased toward the interesting corners: near-gray pixels,
  // ties for the max, tiny values and red and blue pinned near 0 or at 255.
  function automatic pixel_t random_pixel();
    pixel_t          px;
    int              base;
    logic [CH_W-1:0] a, c;
    case ($urandom_range(0, 5))
      0, 1: begin
        px.red   = CH_W'($urandom_range(0, CHAN_MAX));
        px.green = CH_W'($urandom_range(0, CHAN_MAX));
        px.blue  = CH_W'($urandom_range(0, CHAN_MAX));
      end
      2: begin
        base     = $urandom_range(0, CHAN_MAX);
        px.red   = near_byte(base);
        px.green = near_byte(base);
        px.blue  = near_byte(base);
      end
      3: begin
        a = CH_W'($urandom_range(0, CHAN_MAX));
        c = CH_W'($urandom_range(0, CHAN_MAX));
        case ($urandom_range(0, 2))
          0:       px = {a, a, c};
          1:       px = {a, c, a};
          default: px = {c, a, a};
        endcase
      end
      4: begin
        px.red   = CH_W'($urandom_range(0, 7));
        px.green = CH_W'($urandom_range(0, 7));
        px.blue  = CH_W'($urandom_range(0, 7));
      end
      default: begin
        px.red   = ($urandom_range(0, 1) == 1) ? CH_W'(CHAN_MAX) : CH_W'($urandom_range(0, 1));
        px.green = CH_W'($urandom_range(0, CHAN_MAX));
        px.blue  = ($urandom_range(0, 1) == 1) ? CH_W'(CHAN_MAX) : '0;
      end
    endcase
    return px;
  endfunction

  // Clock and reset. Every block input is known from time zero.
  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    pix.valid  = 1'b0;
    pix.red    = '0;
    pix.green  = '0;
    pix.blue   = '0;
    hsv.ready  = 1'b0;
    pix_taken  = 1'b0;
    idle_en    = 1'b1;
    src_gap    = 0;
    snk_gap    = 0;
    fail_cnt   = 0;
    n_checked  = 0;
    n_gray     = 0;
    n_directed = 0;
    n_random   = 0;
    cycles     = 0;
    fork
      forever #5 clk = ~clk;
      begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
      end
    join_none
  end

  // Pixel driver: updates on the falling edge. A new pixel goes out only once
  // the previous one has transferred; gaps come in random bursts.
  always @(negedge clk) begin : pix_drive
    logic   go;
    pixel_t nxt;
    go  = 1'b0;
    nxt = '0;
    if (rst_n && (!pix.valid || pix_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        src_gap = $urandom_range(0, 3);
      end else if (pixel_q.size() != 0) begin
        nxt = pixel_q.pop_front();
        go  = 1'b1;
      end
      pix.valid <= go;
      if (go) begin
        pix.red   <= nxt.red;
        pix.green <= nxt.green;
        pix.blue  <= nxt.blue;
      end
    end
  end

  // Result sink: ready drops for random bursts.
  always @(negedge clk) begin : hsv_drive
    logic rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (snk_gap > 0) begin
        snk_gap--;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        snk_gap = $urandom_range(0, 3);
      end else begin
        rdy = 1'b1;
      end
      hsv.ready <= rdy;
    end
  end

  // Monitor: on the rising edge, a pixel transfer queues its predicted HSV,
  // and a result transfer is checked against the oldest prediction.
  always @(posedge clk) begin : monitor
    pixel_t px;
    hsv_t   want;
    pix_taken = rst_n && pix.valid && pix.ready;
    if (pix_taken) begin
      px = {pix.red, pix.green, pix.blue};
      hsv_owed_q.push_back(hsv_of(px));
    end
    if (rst_n && hsv.valid && hsv.ready) begin
      if (hsv_owed_q.size() == 0) begin
        $error("result transfer with no pixel outstanding: hue %0d sat %0d val %0d",
               hsv.hue, hsv.saturation, hsv.brightness);
        fail_cnt++;
      end else begin
        want = hsv_owed_q.pop_front();
        n_checked++;
        if (want.saturation == '0) n_gray++;
        if (hsv.hue !== want.hue) begin
          $error("hue mismatch: expected %0d, actual %0d", want.hue, hsv.hue);
          fail_cnt++;
        end
        if (hsv.saturation !== want.saturation) begin
          $error("saturation mismatch: expected %0d, actual %0d",
                 want.saturation, hsv.saturation);
          fail_cnt++;
        end
        if (hsv.brightness !== want.brightness) begin
          $error("brightness mismatch: expected %0d, actual %0d",
                 want.brightness, hsv.brightness);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: far above the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles,
               hsv_owed_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Hold the sender until every queued pixel has transferred and every
  // result has come back. Both queues are read on the edge that does not
  // update them; valid is read before its nonblocking update.
  task automatic drain_pipe();
    while (pixel_q.size() != 0) @(posedge clk);
    do @(negedge clk); while (pix.valid || hsv_owed_q.size() != 0);
  endtask

  task automatic add_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    pixel_q.push_back({r, g, b});
    n_directed++;
  endtask

  // Stimulus
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Directed corners: black, white, gray, primaries, smallest nonzero
    // channels, every tie for the max, hue wrap on the red sector, tiny deltas.
    add_pixel(8'd0,   8'd0,   8'd0);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd128, 8'd128, 8'd128);
    add_pixel(8'd1,   8'd1,   8'd1);
    add_pixel(8'd255, 8'd0,   8'd0);
    add_pixel(8'd0,   8'd255, 8'd0);
    add_pixel(8'd0,   8'd0,   8'd255);
    add_pixel(8'd1,   8'd0,   8'd0);
    add_pixel(8'd0,   8'd1,   8'd0);
    add_pixel(8'd0,   8'd0,   8'd1);
    add_pixel(8'd255, 8'd255, 8'd0);    // red and green tie
    add_pixel(8'd0,   8'd255, 8'd255);  // green and blue tie
    add_pixel(8'd255, 8'd0,   8'd255);  // red and blue tie, hue wraps
    add_pixel(8'd200, 8'd100, 8'd200);
    add_pixel(8'd255, 8'd0,   8'd1);    // just below 360 degrees
    add_pixel(8'd10,  8'd0,   8'd5);
    add_pixel(8'd255, 8'd254, 8'd253);
    add_pixel(8'd1,   8'd2,   8'd3);
    add_pixel(8'd128, 8'd127, 8'd1);
    add_pixel(8'd85,  8'd170, 8'd255);
    add_pixel(8'd255, 8'd128, 8'd0);
    add_pixel(8'd170, 8'd85,  8'd255);
    add_pixel(8'd254, 8'd255, 8'd0);
    drain_pipe();

    // Random pixels in chunks; the sender is held between chunks until the
    // pipe is empty. One middle chunk and the last two run with no gaps.
    for (int k = 0; k < N_CHUNKS; k++) begin
      @(posedge clk);
      idle_en = (k < N_CHUNKS - 2) && (k != 3);
      for (int i = 0; i < CHUNK_LEN; i++) begin
        pixel_q.push_back(random_pixel());
        n_random++;
      end
      drain_pipe();
    end

    // Allow for anything still in flight beyond the last owed result.
    repeat (PIPE_DEPTH + 5) @(posedge clk);

    $display("covered %0d directed and %0d random pixels, %0d results checked",
             n_directed, n_random, n_checked);
    $display("%0d results were gray or black, run took %0d cycles", n_gray, cycles);
    if (fail_cnt == 0 && hsv_owed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
